>>> design/assert_macros.svh
// Assertion macros shared by the transcoder RTL.
// Each check is clocked on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/u2u8_pkg.sv
// Shared types and helpers for the UTF-16 to UTF-8 transcoder.
// Used by the front end, the command queue, the back end and the top level.
package u2u8_pkg;

  localparam int unsigned UnitWidth = 16;
  localparam int unsigned CpWidth   = 21;
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // One decoded code point, or an end / error marker, waiting to be sent.
  typedef struct packed {
    kind_e               kind;
    logic [1:0]          last_idx;  // byte count minus one
    logic [CpWidth-1:0]  cp;
  } cmd_t;

  // UTF-8 byte number idx of a code point encoded in last_idx+1 bytes.
  function automatic logic [7:0] utf8_byte(input logic [CpWidth-1:0] cp,
                                           input logic [1:0] last_idx,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (last_idx)
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: begin
        case (idx)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

>>> design/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder, top level: front end, command queue, back end.
// Depends on u2u8_pkg, u2u8_front, u2u8_fifo and u2u8_back.

// One UTF-16 code unit enters per transfer and leaves as one to four result
// transfers, one per UTF-8 byte, with tlast on the final result of that unit.
// A zero unit ends the string with an end marker (tuser = 1); a lone low
// surrogate or an unpaired high surrogate gives one error result (tuser = 2),
// after which units are dropped up to and including the next zero. A high
// surrogate right before the zero gives the error result instead of the end
// marker. A high surrogate alone gives no result until its partner comes.
// The input side takes a unit every cycle while the two-entry command queue
// has room; the output register sends one result per cycle while the
// receiver is ready.
module utf16_to_utf8_transcoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_item
);

  logic           fifo_full, push, pop, cmd_valid;
  u2u8_pkg::cmd_t push_cmd, pop_cmd;

  u2u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_unit_i   (s_axis_tdata),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  u2u8_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .rdata_o (pop_cmd)
  );

  u2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> design/u2u8_front.sv
// Front end: accepts UTF-16 code units, pairs surrogates, tracks the error
// drop state and pushes byte-emission commands. Depends on u2u8_pkg.
`include "assert_macros.svh"

module u2u8_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [u2u8_pkg::UnitWidth-1:0]  in_unit_i,
  input  logic                            fifo_full_i,
  output logic                            push_o,
  output u2u8_pkg::cmd_t                  cmd_o
);

  logic       pending_q, pending_d;
  logic [9:0] high_q, high_d;
  logic       discard_q, discard_d;

  logic accept;
  logic is_zero, is_high, is_low;
  logic has_result;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_zero = (in_unit_i == 16'h0000);
  assign is_high = (in_unit_i[15:10] == 6'b110110);
  assign is_low  = (in_unit_i[15:10] == 6'b110111);

  always_comb begin
    pending_d     = pending_q;
    high_d        = high_q;
    discard_d     = discard_q;
    has_result    = 1'b0;
    cmd_o.kind    = u2u8_pkg::KIND_ERROR;
    cmd_o.last_idx = 2'd0;
    cmd_o.cp      = '0;

    if (discard_q) begin
      // drop everything up to the terminating zero
      if (is_zero) discard_d = 1'b0;
    end else if (pending_q) begin
      pending_d  = 1'b0;
      has_result = 1'b1;
      if (is_low) begin
        cmd_o.kind     = u2u8_pkg::KIND_DATA;
        cmd_o.last_idx = 2'd3;
        cmd_o.cp       = {1'b0, high_q, in_unit_i[9:0]} + 21'h10000;
      end else if (!is_zero) begin
        discard_d = 1'b1;
      end
    end else if (is_zero) begin
      has_result = 1'b1;
      cmd_o.kind = u2u8_pkg::KIND_END;
    end else if (is_high) begin
      pending_d = 1'b1;
      high_d    = in_unit_i[9:0];
    end else if (is_low) begin
      has_result = 1'b1;
      discard_d  = 1'b1;
    end else begin
      has_result = 1'b1;
      cmd_o.kind = u2u8_pkg::KIND_DATA;
      cmd_o.cp   = {5'd0, in_unit_i};
      if (in_unit_i[15:7] == 9'd0) begin
        cmd_o.last_idx = 2'd0;
      end else if (in_unit_i[15:11] == 5'd0) begin
        cmd_o.last_idx = 2'd1;
      end else begin
        cmd_o.last_idx = 2'd2;
      end
    end
  end

  assign push_o = accept && has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      high_q    <= '0;
      discard_q <= 1'b0;
    end else if (accept) begin
      pending_q <= pending_d;
      high_q    <= high_d;
      discard_q <= discard_d;
    end
  end

  `ASSERT_ALWAYS(a_no_pending_while_drop, !(pending_q && discard_q), "pending while dropping")
  `ASSERT_IMPLIES(a_push_needs_room, push_o, !fifo_full_i, "push into a full queue")

endmodule

>>> design/u2u8_fifo.sv
// Two-entry command queue between front end and back end.
// Register based, one push and one pop per cycle. Depends on u2u8_pkg.
`include "assert_macros.svh"

module u2u8_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  u2u8_pkg::cmd_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output u2u8_pkg::cmd_t rdata_o
);

  u2u8_pkg::cmd_t mem_q [u2u8_pkg::FifoDepth];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = (count_q == 2'(u2u8_pkg::FifoDepth));
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 2'd1;
    if (!do_push && do_pop) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count_q <= 2'(u2u8_pkg::FifoDepth), "queue count overflow")
  `ASSERT_IMPLIES(a_empty_ptrs, count_q == 2'd0, wr_ptr_q == rd_ptr_q, "pointers differ when empty")

endmodule

>>> design/u2u8_back.sv
// Back end: takes commands from the queue and sends one result per cycle,
// while the receiver is ready, through an output register. Depends on u2u8_pkg.
`include "assert_macros.svh"

module u2u8_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  u2u8_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic [1:0]     out_kind_o,
  output logic           out_last_o
);

  logic           busy_q;
  u2u8_pkg::cmd_t cmd_q;
  logic [1:0]     idx_q;
  logic           oval_q;
  logic [7:0]     obyte_q, obyte_d;
  logic [1:0]     okind_q;
  logic           olast_q;

  logic out_free, at_last, emit;

  assign out_free = !oval_q || out_ready_i;
  assign at_last  = (idx_q == cmd_q.last_idx);
  assign emit     = busy_q && out_free;
  assign pop_o    = cmd_valid_i && (!busy_q || (emit && at_last));

  always_comb begin
    if (cmd_q.kind == u2u8_pkg::KIND_DATA) begin
      obyte_d = u2u8_pkg::utf8_byte(cmd_q.cp, cmd_q.last_idx, idx_q);
    end else begin
      obyte_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
      oval_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 2'd0;
      end else if (emit) begin
        if (at_last) busy_q <= 1'b0;
        idx_q <= idx_q + 2'd1;
      end
      if (out_free) oval_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (emit) begin
      obyte_q <= obyte_d;
      okind_q <= cmd_q.kind;
      olast_q <= at_last;
    end
  end

  assign out_valid_o = oval_q;
  assign out_byte_o  = obyte_q;
  assign out_kind_o  = okind_q;
  assign out_last_o  = olast_q;

  `ASSERT_IMPLIES(a_idx_in_range, busy_q, idx_q <= cmd_q.last_idx, "byte index past end")
  `ASSERT_IMPLIES(a_marker_single, busy_q && cmd_q.kind != u2u8_pkg::KIND_DATA,
                  cmd_q.last_idx == 2'd0, "marker with several bytes")

endmodule

>>> tb/sv/utf16_to_utf8_transcoder_test.sv
// Self-checking test of utf16_to_utf8_transcoder: random and directed UTF-16 strings in,
// UTF-8 bytes, end markers and error markers checked against a built-in predictor.
// Depends on u2u8_pkg for the result kind codes.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_test;

  localparam int StallCycles   = 300;
  localparam int WatchdogLimit = 5000;
  localparam int RandomUnits   = 350;

  typedef struct {
    logic [7:0]      out_byte;
    u2u8_pkg::kind_e kind;
    logic            is_last;
  } utf8_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] code_unit
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] out_byte
  logic [1:0]  m_axis_tuser;        // [1:0] kind
  logic        m_axis_tlast;        // last_of_item

  utf16_to_utf8_transcoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  logic [15:0]  pending_units[$];
  utf8_result_t utf8_expected[$];

  // Predictor state
  logic       held_high = 1'b0;
  logic [9:0] held_payload = '0;
  logic       dropping_units = 1'b0;

  int units_sent = 0;
  int total_units = 1;
  int results_checked = 0;
  int ends_seen = 0;
  int errors_seen = 0;
  int mismatch_count = 0;
  int stall_left = 0;
  bit stall_done = 1'b0;
  int quiet_cycles = 0;
  int gen_count = 0;
  bit gen_dropping = 1'b0;

  function automatic void expect_result(input utf8_result_t r);
    utf8_expected = {utf8_expected, r};
  endfunction

  function automatic void expect_code_point(input logic [20:0] cp);
    logic [7:0] b [4];
    int n;
    utf8_result_t r;
    if (cp < 21'h80) begin
      b[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      b[0] = {3'b110, cp[10:6]};
      b[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      b[0] = {4'b1110, cp[15:12]};
      b[1] = {2'b10, cp[11:6]};
      b[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
      n = 4;
    end
    for (int i = 0; i < n; i++) begin
      r.out_byte = b[i];
      r.kind     = u2u8_pkg::KIND_DATA;
      r.is_last  = (i == n - 1);
      expect_result(r);
    end
  endfunction

  function automatic void expect_marker(input u2u8_pkg::kind_e kind);
    utf8_result_t r;
    r.out_byte = 8'h00;
    r.kind     = kind;
    r.is_last  = 1'b1;
    expect_result(r);
  endfunction

  function automatic void transcode_unit(input logic [15:0] unit);
    logic is_high, is_low;
    is_high = (unit[15:10] == 6'b110110);
    is_low  = (unit[15:10] == 6'b110111);
    if (dropping_units) begin
      if (unit == 16'h0000) dropping_units = 1'b0;
    end else if (held_high) begin
      held_high = 1'b0;
      if (unit == 16'h0000) begin
        expect_marker(u2u8_pkg::KIND_ERROR);
      end else if (is_low) begin
        expect_code_point({1'b0, held_payload, unit[9:0]} + 21'h10000);
      end else begin
        // the unit that broke the pair is dropped along with the rest
        dropping_units = 1'b1;
        expect_marker(u2u8_pkg::KIND_ERROR);
      end
    end else if (unit == 16'h0000) begin
      expect_marker(u2u8_pkg::KIND_END);
    end else if (is_high) begin
      held_high = 1'b1;
      held_payload = unit[9:0];
    end else if (is_low) begin
      dropping_units = 1'b1;
      expect_marker(u2u8_pkg::KIND_ERROR);
    end else begin
      expect_code_point({5'd0, unit});
    end
  endfunction

  function automatic int idle_pct(input bit receiver);
    int phase;
    phase = (units_sent * 3) / total_units;
    if (phase == 0) return receiver ? 75 : 18;
    if (phase == 1) return receiver ? 18 : 75;
    return 0;
  endfunction

  function automatic void check_result();
    utf8_result_t want;
    if (utf8_expected.size() == 0) begin
      $error("unexpected result: out_byte %h kind %0d last %b",
             m_axis_tdata, m_axis_tuser, m_axis_tlast);
      mismatch_count++;
      return;
    end
    want = utf8_expected.pop_front();
    results_checked++;
    if (want.kind == u2u8_pkg::KIND_END) ends_seen++;
    if (want.kind == u2u8_pkg::KIND_ERROR) errors_seen++;
    if (m_axis_tdata !== want.out_byte) begin
      $error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata);
      mismatch_count++;
    end
    if (m_axis_tuser !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
      mismatch_count++;
    end
    if (m_axis_tlast !== want.is_last) begin
      $error("last_of_item: expected %b, got %b", want.is_last, m_axis_tlast);
      mismatch_count++;
    end
  endfunction

  // Sender: advance to the next unit once the current one is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        transcode_unit(s_axis_tdata);
        units_sent <= units_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_units.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_units.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer, stall at random, and once hold off long
  // enough for the block to back up into its input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!stall_done && units_sent >= (total_units * 3) / 4) begin
        stall_done = 1'b1;
        stall_left = StallCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: no transfer for %0d cycles", WatchdogLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Units the block will only drop are not counted toward the random total
  function automatic void add_unit(input logic [15:0] unit);
    pending_units = {pending_units, unit};
    if (!gen_dropping) gen_count++;
    if (unit == 16'h0000) gen_dropping = 1'b0;
  endfunction

  function automatic void add_char();
    case ($urandom_range(3))
      0: add_unit(16'($urandom_range(16'h0001, 16'h007F)));
      1: add_unit(16'($urandom_range(16'h0080, 16'h07FF)));
      2: begin
        if ($urandom_range(1))
          add_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
        else
          add_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
      end
      default: begin
        add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
        add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end
    endcase
  endfunction

  initial begin
    int len, fault, at;
    bit ended;

    // Directed: byte-length boundaries, surrogate extremes, every fault
    add_unit(16'h0001); add_unit(16'h007F); add_unit(16'h0080); add_unit(16'h07FF);
    add_unit(16'h0800); add_unit(16'hD7FF); add_unit(16'hE000); add_unit(16'hFFFF);
    add_unit(16'hD800); add_unit(16'hDC00); add_unit(16'hDBFF); add_unit(16'hDFFF);
    add_unit(16'h0000);
    // lone low surrogate, then dropped units up to the zero
    add_unit(16'hDC00); add_unit(16'h0041); add_unit(16'h0000);
    // high surrogate right before the zero
    add_unit(16'hDBFF); add_unit(16'h0000);
    // high surrogate broken by a plain unit, then by another high
    add_unit(16'hD800); add_unit(16'h0041); add_unit(16'h0042); add_unit(16'h0000);
    add_unit(16'hDA00); add_unit(16'hD900); add_unit(16'h0000);
    add_unit(16'h0000);

    gen_count = 0;
    while (gen_count < RandomUnits) begin
      len = $urandom_range(0, 8);
      fault = ($urandom_range(99) < 20) ? $urandom_range(1, 4) : 0;
      at = $urandom_range(0, len);
      ended = 1'b0;
      for (int i = 0; i <= len && !ended; i++) begin
        if (fault != 0 && i == at) begin
          case (fault)
            1: begin
              add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
              gen_dropping = 1'b1;
            end
            2: begin
              add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
              ended = 1'b1;
            end
            3: begin
              add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
              if ($urandom_range(1))
                add_unit(16'($urandom_range(16'h0001, 16'hD7FF)));
              else
                add_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
              gen_dropping = 1'b1;
            end
            default: add_unit(16'($urandom_range(0, 16'hFFFF)));
          endcase
        end
        if (i < len && !ended) add_char();
      end
      add_unit(16'h0000);
    end
    total_units = pending_units.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_units.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (utf8_expected.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d code units; checked %0d results (%0d strings ended, %0d errors).",
             total_units, results_checked, ends_seen, errors_seen);
    $display("Idle patterns: slow sender, slow receiver, none, plus one long output stall.");
    if (mismatch_count == 0 && utf8_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/u2u8_pkg.sv
design/u2u8_front.sv
design/u2u8_fifo.sv
design/u2u8_back.sv
design/utf16_to_utf8_transcoder.sv
tb/sv/utf16_to_utf8_transcoder_test.sv
